FILE: hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the page allocator
// Operation and status codes, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int C_MAX_PAGES    = 4096;
    localparam int C_PAGE_SHIFT   = 12;
    localparam int C_ADDR_W       = 32;
    localparam int C_END_W        = 33;
    localparam int C_FREE_W       = 13;
    localparam int C_CFG_IDX_W    = 1;
    localparam int C_IN_TDATA_W   = 32;
    localparam int C_IN_TUSER_W   = 2;
    localparam int C_OUT_TDATA_W  = 48;
    localparam int C_OUT_TUSER_W  = 3;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_TAKE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_ZERO      = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        REG_PAGE_BASE  = 1'b0,
        REG_PAGE_LIMIT = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_FILL,
        S_ALLOC,
        S_ALLOC_WB,
        S_FREE,
        S_TAKE,
        S_TAKE_RD,
        S_TAKE_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_POST
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_FILL,
        OP_POP_RD,
        OP_POP_LATCH,
        OP_PUSH,
        OP_SRCH_START,
        OP_SRCH_NEXT,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_SHIFT_END
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    set_st;
        t_status st;
        logic    post;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic addr_zero;
        logic fill_more;
        logic hit;
        logic idx_zero;
        logic shift_more;
        logic out_busy;
    } t_dp_sts;

endpackage

FILE: hdl/fpa_ctrl.sv
// ----------------------------------------------------------------------------
// fpa_ctrl: page allocator sequencer
// Takes one word at a time, steps the datapath through fill, pop, push,
// search and close-up passes, then posts the result word.
// ----------------------------------------------------------------------------
module fpa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  fpa_pkg::t_mode  i_mode,
    input  fpa_pkg::t_dp_sts i_sts,
    output logic            o_in_ready,
    output fpa_pkg::t_dp_cmd o_cmd
);
    import fpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode)
                        MODE_INIT:  n_state = S_INIT;
                        MODE_ALLOC: n_state = S_ALLOC;
                        MODE_FREE:  n_state = S_FREE;
                        MODE_TAKE:  n_state = S_TAKE;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_INIT:     n_state = S_FILL;
            S_FILL:     n_state = i_sts.fill_more ? S_FILL : S_POST;
            S_ALLOC:    n_state = i_sts.cnt_zero ? S_POST : S_ALLOC_WB;
            S_ALLOC_WB: n_state = S_POST;
            S_FREE:     n_state = S_POST;
            S_TAKE:     n_state = i_sts.cnt_zero ? S_POST : S_TAKE_RD;
            S_TAKE_RD:  n_state = S_TAKE_CMP;
            S_TAKE_CMP: begin
                if (i_sts.hit) begin
                    n_state = S_SHIFT_RD;
                end else if (i_sts.idx_zero) begin
                    n_state = S_POST;
                end else begin
                    n_state = S_TAKE_RD;
                end
            end
            S_SHIFT_RD: n_state = i_sts.shift_more ? S_SHIFT_WR : S_POST;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_POST:     n_state = i_sts.out_busy ? S_POST : S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.set_st = 1'b0;
        o_cmd.st    = ST_OK;
        o_cmd.post  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            S_INIT: o_cmd.op = OP_INIT;
            S_FILL: begin
                if (i_sts.fill_more) begin
                    o_cmd.op = OP_FILL;
                end
            end
            S_ALLOC: begin
                if (i_sts.cnt_zero) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_EMPTY;
                end else begin
                    o_cmd.op = OP_POP_RD;
                end
            end
            S_ALLOC_WB: o_cmd.op = OP_POP_LATCH;
            S_FREE: begin
                if (i_sts.addr_zero) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_ZERO;
                end else if (i_sts.cnt_full) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_FULL;
                end else begin
                    o_cmd.op = OP_PUSH;
                end
            end
            S_TAKE: begin
                if (i_sts.cnt_zero) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_NOT_FOUND;
                end else begin
                    o_cmd.op = OP_SRCH_START;
                end
            end
            S_TAKE_RD: o_cmd.op = OP_NONE;
            S_TAKE_CMP: begin
                if (!i_sts.hit) begin
                    if (i_sts.idx_zero) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = ST_NOT_FOUND;
                    end else begin
                        o_cmd.op = OP_SRCH_NEXT;
                    end
                end
            end
            S_SHIFT_RD: o_cmd.op = i_sts.shift_more ? OP_SHIFT_RD : OP_SHIFT_END;
            S_SHIFT_WR: o_cmd.op = OP_SHIFT_WR;
            S_POST:     o_cmd.post = !i_sts.out_busy;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

endmodule

FILE: hdl/fpa_dp.sv
// ----------------------------------------------------------------------------
// fpa_dp: page allocator datapath
// Stack memory, entry count, fill pointer, search index, region registers
// and the output word register.
// ----------------------------------------------------------------------------
module fpa_dp #(
    parameter int MAX_PAGES = fpa_pkg::C_MAX_PAGES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fpa_pkg::C_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fpa_pkg::C_END_W-1:0]       i_cfg_data,
    input  logic [fpa_pkg::C_ADDR_W-1:0]      i_addr,
    input  fpa_pkg::t_dp_cmd                  i_cmd,
    output fpa_pkg::t_dp_sts                  o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [fpa_pkg::C_ADDR_W-1:0]      o_page_address,
    output fpa_pkg::t_status                  o_status,
    output logic [fpa_pkg::C_FREE_W-1:0]      o_free_pages
);
    import fpa_pkg::*;

    localparam int AW = $clog2(MAX_PAGES);
    localparam int CW = $clog2(MAX_PAGES + 1);

    logic [C_ADDR_W-1:0] r_mem [MAX_PAGES];
    logic [C_ADDR_W-1:0] r_rdata;

    logic [C_ADDR_W-1:0] r_begin;
    logic [C_END_W-1:0]  r_end;
    logic [C_ADDR_W-1:0] r_addr;
    logic [CW-1:0]       r_count;
    logic [C_END_W-1:0]  r_page;
    logic [AW-1:0]       r_idx;
    logic [C_ADDR_W-1:0] r_res_page;
    t_status             r_res_status;

    logic                r_out_valid;
    logic [C_ADDR_W-1:0] r_out_page;
    t_status             r_out_status;
    logic [C_FREE_W-1:0] r_out_free;

    logic [CW-1:0]        cnt_m1;
    logic [CW-1:0]        idx_p1;
    logic [CW-1:0]        idx_p2;
    logic [C_END_W:0]     page_next;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;
    logic [C_ADDR_W-1:0]  wr_data;
    logic [C_FREE_W+CW-1:0] free_ext;

    assign cnt_m1    = r_count - CW'(1);
    assign idx_p1    = CW'(r_idx) + CW'(1);
    assign idx_p2    = CW'(r_idx) + CW'(2);
    assign page_next = {1'b0, r_page} + (C_END_W+1)'(1 << C_PAGE_SHIFT);
    assign free_ext  = {{C_FREE_W{1'b0}}, r_count};

    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.cnt_full   = (r_count == CW'(MAX_PAGES));
    assign o_sts.addr_zero  = (r_addr == '0);
    assign o_sts.fill_more  = (page_next <= {1'b0, r_end}) && (r_count != CW'(MAX_PAGES));
    assign o_sts.hit        = (r_rdata == r_addr);
    assign o_sts.idx_zero   = (r_idx == '0);
    assign o_sts.shift_more = (idx_p1 < r_count);
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    // memory port selection
    always_comb begin
        rd_addr = r_idx;
        mem_we  = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = r_addr;
        case (i_cmd.op)
            OP_POP_RD:   rd_addr = cnt_m1[AW-1:0];
            OP_SHIFT_RD: rd_addr = idx_p1[AW-1:0];
            OP_FILL: begin
                mem_we  = 1'b1;
                wr_data = r_page[C_ADDR_W-1:0];
            end
            OP_PUSH:     mem_we = 1'b1;
            OP_SHIFT_WR: begin
                mem_we  = 1'b1;
                wr_addr = r_idx;
                wr_data = r_rdata;
            end
            default:     rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin <= '0;
            r_end   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_PAGE_BASE:  r_begin <= i_cfg_data[C_ADDR_W-1:0];
                REG_PAGE_LIMIT: r_end   <= i_cfg_data;
                default:        r_end   <= r_end;
            endcase
        end
    end

    // stack count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.op)
                OP_INIT:      r_count <= '0;
                OP_FILL:      r_count <= r_count + CW'(1);
                OP_PUSH:      r_count <= r_count + CW'(1);
                OP_POP_RD:    r_count <= cnt_m1;
                OP_SHIFT_END: r_count <= cnt_m1;
                default:      r_count <= r_count;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_addr       <= i_addr;
                r_res_page   <= '0;
                r_res_status <= ST_OK;
            end
            OP_INIT:       r_page <= {1'b0, r_begin};
            OP_FILL:       r_page <= page_next[C_END_W-1:0];
            OP_POP_LATCH:  r_res_page <= r_rdata;
            OP_SRCH_START: begin
                // align down to the page boundary, start at the top entry
                r_addr <= {r_addr[C_ADDR_W-1:C_PAGE_SHIFT], {C_PAGE_SHIFT{1'b0}}};
                r_idx  <= cnt_m1[AW-1:0];
            end
            OP_SRCH_NEXT:  r_idx <= r_idx - AW'(1);
            OP_SHIFT_WR:   r_idx <= idx_p2[AW-1:0] - AW'(1);
            default:       r_idx <= r_idx;
        endcase
        if (i_cmd.set_st) begin
            r_res_status <= i_cmd.st;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out_page   <= r_res_page;
            r_out_status <= r_res_status;
            r_out_free   <= free_ext[C_FREE_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_page_address = r_out_page;
    assign o_status       = r_out_status;
    assign o_free_pages   = r_out_free;

endmodule

FILE: hdl/free_list_page_allocator.sv
// ----------------------------------------------------------------------------
// free_list_page_allocator: LIFO free list of 4096-byte pages
// Stack of free page addresses in a one-write, one-read memory.
// ----------------------------------------------------------------------------
// One word in gives one word out. Words are handled one at a time, and the
// stack memory moves one entry per cycle on each port, with registered read
// data. Free pushes the address unless it is zero or the list is full;
// allocate reads the top entry and latches it, unless the list is empty;
// initialise pushes the pages that fit between the base and the limit; take
// searches the entries from the top down and, on a match, closes up the
// entries above it. The result word becomes valid in the same cycle that
// the next word can be accepted. A new word is accepted while the previous
// result still waits on the output; its own result then holds until that
// earlier word is taken.
// The stack memory is never cleared; only entries below the count are used.
// Program the page base and limit registers while idle, then send an
// initialise.
// ----------------------------------------------------------------------------
module free_list_page_allocator #(
    parameter int MAX_PAGES = fpa_pkg::C_MAX_PAGES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fpa_pkg::C_CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fpa_pkg::C_END_W-1:0]         i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fpa_pkg::C_IN_TDATA_W-1:0]    s_axis_tdata,   // [31:0] address
    input  logic [fpa_pkg::C_IN_TUSER_W-1:0]    s_axis_tuser,   // [1:0] mode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fpa_pkg::C_OUT_TDATA_W-1:0]   m_axis_tdata,   // [31:0] page_address,
                                                                // [44:32] free_pages
    output logic [fpa_pkg::C_OUT_TUSER_W-1:0]   m_axis_tuser    // [2:0] status
);
    import fpa_pkg::*;

    t_dp_cmd             cmd;
    t_dp_sts             sts;
    t_status             out_status;
    logic [C_ADDR_W-1:0] out_page;
    logic [C_FREE_W-1:0] out_free;

    fpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_mode     (t_mode'(s_axis_tuser)),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    fpa_dp #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_addr         (s_axis_tdata),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_page_address (out_page),
        .o_status       (out_status),
        .o_free_pages   (out_free)
    );

    assign m_axis_tdata = {{(C_OUT_TDATA_W - C_ADDR_W - C_FREE_W){1'b0}}, out_free, out_page};
    assign m_axis_tuser = out_status;

endmodule
